// ===== rtl/encoder_velocity_estimator_core_defines.svh =====
// Assertion macros for the encoder velocity estimator checker
`ifndef ENCODER_VELOCITY_ESTIMATOR_CORE_DEFINES_SVH
`define ENCODER_VELOCITY_ESTIMATOR_CORE_DEFINES_SVH

// same-cycle implication, disabled while reset is held
`define EVEST_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("evest same-cycle check failed");

// next-cycle implication, disabled while reset is held
`define EVEST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("evest next-cycle check failed");

`endif

// ===== rtl/evest_pkg.sv =====
// Types and constants shared by the encoder velocity estimator modules
package evest_pkg;

  localparam int ANGLE_W = 12;
  localparam int ELAPSED_W = 20;
  localparam int DELTA_W = 13;
  localparam int MAG_W = 12;
  localparam int SPEED_W = 32;
  localparam int DIST_W = 48;
  localparam int MAXSPD_W = 16;
  localparam int CIRC_W = 20;
  localparam int ALPHA_W = 17;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 20;
  localparam int NUM_W = 35;
  localparam int LIMIT_W = 25;
  localparam int RATE_W = 26;
  localparam int LHS_W = 28;
  localparam int RHS_W = 36;
  localparam int ACC_W = 50;
  localparam int DIV_CNT_W = 6;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CIRC = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REVERSE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA = 2'd3;

  localparam logic [MAXSPD_W-1:0] RST_MAX_SPEED = 16'd1280;
  localparam logic [CIRC_W-1:0] RST_CIRC = 20'd200000;
  localparam logic [ALPHA_W-1:0] RST_ALPHA = 17'd6554;
  localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'd65536;

  localparam logic [16:0] CHK_SCALE = 17'd125000;
  localparam logic [23:0] RATE_SCALE = 24'd16000000;
  // max_speed * 1472 / 5, as a reciprocal multiply exact for 16-bit inputs
  localparam logic [26:0] LIMIT_MULT = 27'd77175194;
  localparam int LIMIT_SHIFT = 18;
  localparam logic [DIV_CNT_W-1:0] DIV_STEPS = 6'd35;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DELTA,
    ST_CHK_LHS,
    ST_CHK_RHS,
    ST_CHECK,
    ST_NUM,
    ST_LIMIT,
    ST_DIV,
    ST_CLAMP,
    ST_DIST,
    ST_EMA_NEW,
    ST_EMA_OLD,
    ST_EMA_ROUND,
    ST_FIN
  } evest_state_t;

  typedef struct packed {
    logic load;
    logic delta;
    logic lhs;
    logic rhs;
    logic check;
    logic num;
    logic limit;
    logic div_start;
    logic clamp;
    logic dist_add;
    logic ema_new;
    logic ema_old;
    logic ema_round;
    logic emit;
  } evest_cmd_t;

  typedef struct packed {
    logic clear;
    logic glitch;
    logic div_done;
    logic out_busy;
  } evest_sts_t;

endpackage

// ===== rtl/evest_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle
module evest_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [evest_pkg::NUM_W-1:0]     num,
  input  logic [evest_pkg::ELAPSED_W-1:0] den,
  output logic                            done,
  output logic [evest_pkg::NUM_W-1:0]     quo
);

  logic                              busy_r;
  logic                              done_r;
  logic [evest_pkg::DIV_CNT_W-1:0]   cnt_r;
  logic [evest_pkg::NUM_W-1:0]       quo_r;
  logic [evest_pkg::ELAPSED_W-1:0]   rem_r;
  logic [evest_pkg::ELAPSED_W:0]     shifted;
  logic [evest_pkg::ELAPSED_W:0]     diff;
  logic                              fits;

  assign shifted = {rem_r, quo_r[evest_pkg::NUM_W-1]};
  assign diff = shifted - {1'b0, den};
  assign fits = (shifted >= {1'b0, den});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r <= evest_pkg::DIV_STEPS;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= num;
      rem_r <= '0;
    end else if (busy_r) begin
      quo_r <= {quo_r[evest_pkg::NUM_W-2:0], fits};
      rem_r <= fits ? diff[evest_pkg::ELAPSED_W-1:0] : shifted[evest_pkg::ELAPSED_W-1:0];
    end
  end

  assign done = done_r;
  assign quo = quo_r;

endmodule

// ===== rtl/evest_dp.sv =====
// Datapath: configuration, estimator state, arithmetic steps and result register
module evest_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  evest_pkg::evest_cmd_t            cmd,
  output evest_pkg::evest_sts_t            sts,
  input  logic                             in_action,
  input  logic [evest_pkg::ANGLE_W-1:0]    in_angle,
  input  logic [evest_pkg::ELAPSED_W-1:0]  in_elapsed_us,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [evest_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [evest_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [evest_pkg::SPEED_W-1:0] out_speed,
  output logic signed [evest_pkg::DIST_W-1:0]  out_distance,
  output logic                             out_glitch
);

  logic [evest_pkg::MAXSPD_W-1:0]  max_r;
  logic [evest_pkg::CIRC_W-1:0]    circ_r;
  logic                            rev_r;
  logic [evest_pkg::ALPHA_W-1:0]   alpha_r;

  logic [evest_pkg::ANGLE_W-1:0]   prev_r;
  logic signed [evest_pkg::SPEED_W-1:0] filt_r;
  logic signed [evest_pkg::DIST_W-1:0]  dist_r;

  logic                            act_r;
  logic [evest_pkg::ANGLE_W-1:0]   ang_r;
  logic [evest_pkg::ELAPSED_W-1:0] ela_r;
  logic signed [evest_pkg::DELTA_W-1:0] d_r;
  logic signed [evest_pkg::DELTA_W-1:0] dr_r;
  logic [evest_pkg::MAG_W-1:0]     mag_r;
  logic [evest_pkg::LHS_W-1:0]     lhs_r;
  logic [evest_pkg::RHS_W-1:0]     rhs_r;
  logic                            glitch_r;
  logic [evest_pkg::NUM_W-1:0]     num_r;
  logic [evest_pkg::LIMIT_W-1:0]   lim_r;
  logic signed [evest_pkg::RATE_W-1:0] rate_r;
  logic signed [evest_pkg::ACC_W-1:0]  acc_r;

  logic                            out_valid_r;
  logic signed [evest_pkg::SPEED_W-1:0] out_speed_r;
  logic signed [evest_pkg::DIST_W-1:0]  out_dist_r;
  logic                            out_glitch_r;

  logic signed [evest_pkg::DELTA_W:0]   diff;
  logic signed [evest_pkg::DELTA_W:0]   wrapped;
  logic signed [evest_pkg::DELTA_W-1:0] d_nxt;
  logic signed [evest_pkg::DELTA_W-1:0] d_abs;
  logic [evest_pkg::RHS_W+1:0]     rhs3;
  logic                            glitch_nxt;
  logic [35:0]                     num_full;
  logic [42:0]                     lim_full;
  logic                            div_done;
  logic [evest_pkg::NUM_W-1:0]     quo;
  logic [evest_pkg::LIMIT_W-1:0]   qc;
  logic signed [evest_pkg::RATE_W-1:0] rate_nxt;
  logic signed [33:0]              dprod;
  logic [evest_pkg::ALPHA_W-1:0]   alpha_c;
  logic [evest_pkg::ALPHA_W-1:0]   beta;
  logic signed [43:0]              p_new;
  logic signed [evest_pkg::ACC_W-1:0] p_old;
  logic signed [evest_pkg::ACC_W-1:0] rsum;

  assign diff = $signed({2'b00, ang_r}) - $signed({2'b00, prev_r});

  always_comb begin
    if (diff > 14'sd2048) begin
      wrapped = diff - 14'sd4096;
    end else if (diff < -14'sd2048) begin
      wrapped = diff + 14'sd4096;
    end else begin
      wrapped = diff;
    end
    d_nxt = wrapped[evest_pkg::DELTA_W-1:0];
    d_abs = d_nxt[evest_pkg::DELTA_W-1] ? -d_nxt : d_nxt;
  end

  assign rhs3 = {2'b00, rhs_r} + {1'b0, rhs_r, 1'b0};
  assign glitch_nxt = (ela_r == '0) || ({10'd0, lhs_r} > rhs3);
  assign num_full = {24'd0, mag_r} * {12'd0, evest_pkg::RATE_SCALE};
  assign lim_full = {27'd0, max_r} * {16'd0, evest_pkg::LIMIT_MULT};

  evest_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (num_r),
    .den   (ela_r),
    .done  (div_done),
    .quo   (quo)
  );

  always_comb begin
    qc = (quo > {10'd0, lim_r}) ? lim_r : quo[evest_pkg::LIMIT_W-1:0];
    rate_nxt = dr_r[evest_pkg::DELTA_W-1] ? -$signed({1'b0, qc}) : $signed({1'b0, qc});
  end

  assign dprod = $signed({{21{dr_r[evest_pkg::DELTA_W-1]}}, dr_r}) * $signed({14'd0, circ_r});
  assign alpha_c = (alpha_r > evest_pkg::ALPHA_ONE) ? evest_pkg::ALPHA_ONE : alpha_r;
  assign beta = evest_pkg::ALPHA_ONE - alpha_c;
  assign p_new = $signed({27'd0, alpha_c}) *
                 $signed({{18{rate_r[evest_pkg::RATE_W-1]}}, rate_r});
  assign p_old = $signed({33'd0, beta}) *
                 $signed({{18{filt_r[evest_pkg::SPEED_W-1]}}, filt_r});
  assign rsum = acc_r + 50'sd32768;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r <= evest_pkg::RST_MAX_SPEED;
      circ_r <= evest_pkg::RST_CIRC;
      rev_r <= 1'b0;
      alpha_r <= evest_pkg::RST_ALPHA;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        evest_pkg::CFG_MAX_SPEED: max_r <= cfg_data[evest_pkg::MAXSPD_W-1:0];
        evest_pkg::CFG_CIRC:      circ_r <= cfg_data;
        evest_pkg::CFG_REVERSE:   rev_r <= cfg_data[0];
        evest_pkg::CFG_ALPHA:     alpha_r <= cfg_data[evest_pkg::ALPHA_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
      filt_r <= '0;
      dist_r <= '0;
      glitch_r <= 1'b0;
      act_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        act_r <= in_action;
        glitch_r <= 1'b0;
        if (in_action) begin
          dist_r <= '0;
        end
      end
      if (cmd.delta) begin
        prev_r <= ang_r;
      end
      if (cmd.check) begin
        glitch_r <= glitch_nxt;
      end
      if (cmd.dist_add) begin
        dist_r <= dist_r + {{(evest_pkg::DIST_W-34){dprod[33]}}, dprod};
      end
      if (cmd.ema_round) begin
        filt_r <= rsum[evest_pkg::SPEED_W+15:16];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ang_r <= in_angle;
      ela_r <= in_elapsed_us;
    end
    if (cmd.delta) begin
      d_r <= d_nxt;
      mag_r <= d_abs[evest_pkg::MAG_W-1:0];
    end
    if (cmd.lhs) begin
      lhs_r <= {16'd0, mag_r} * {11'd0, evest_pkg::CHK_SCALE};
    end
    if (cmd.rhs) begin
      rhs_r <= {20'd0, max_r} * {16'd0, ela_r};
    end
    if (cmd.check) begin
      dr_r <= rev_r ? -d_r : d_r;
    end
    if (cmd.num) begin
      num_r <= num_full[evest_pkg::NUM_W-1:0];
    end
    if (cmd.limit) begin
      lim_r <= lim_full[evest_pkg::LIMIT_SHIFT+evest_pkg::LIMIT_W-1:evest_pkg::LIMIT_SHIFT];
    end
    if (cmd.clamp) begin
      rate_r <= rate_nxt;
    end
    if (cmd.ema_new) begin
      acc_r <= {{(evest_pkg::ACC_W-44){p_new[43]}}, p_new};
    end else if (cmd.ema_old) begin
      acc_r <= acc_r + p_old;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_speed_r <= filt_r;
      out_dist_r <= dist_r;
      out_glitch_r <= glitch_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_speed = out_speed_r;
  assign out_distance = out_dist_r;
  assign out_glitch = out_glitch_r;

  assign sts.clear = act_r;
  assign sts.glitch = glitch_r;
  assign sts.div_done = div_done;
  assign sts.out_busy = out_valid_r && out_stall;

endmodule

// ===== rtl/evest_ctrl.sv =====
// Controller: sequences one sample through the datapath steps
module evest_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  evest_pkg::evest_sts_t sts,
  output evest_pkg::evest_cmd_t cmd
);

  evest_pkg::evest_state_t state_r;
  evest_pkg::evest_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= evest_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_stall = (state_r != evest_pkg::ST_IDLE);
    case (state_r)
      evest_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = evest_pkg::ST_DELTA;
        end
      end
      evest_pkg::ST_DELTA: begin
        if (sts.clear) begin
          state_nxt = evest_pkg::ST_FIN;
        end else begin
          cmd.delta = 1'b1;
          state_nxt = evest_pkg::ST_CHK_LHS;
        end
      end
      evest_pkg::ST_CHK_LHS: begin
        cmd.lhs = 1'b1;
        state_nxt = evest_pkg::ST_CHK_RHS;
      end
      evest_pkg::ST_CHK_RHS: begin
        cmd.rhs = 1'b1;
        state_nxt = evest_pkg::ST_CHECK;
      end
      evest_pkg::ST_CHECK: begin
        cmd.check = 1'b1;
        state_nxt = evest_pkg::ST_NUM;
      end
      evest_pkg::ST_NUM: begin
        if (sts.glitch) begin
          state_nxt = evest_pkg::ST_FIN;
        end else begin
          cmd.num = 1'b1;
          state_nxt = evest_pkg::ST_LIMIT;
        end
      end
      evest_pkg::ST_LIMIT: begin
        cmd.limit = 1'b1;
        cmd.div_start = 1'b1;
        state_nxt = evest_pkg::ST_DIV;
      end
      evest_pkg::ST_DIV: begin
        if (sts.div_done) begin
          state_nxt = evest_pkg::ST_CLAMP;
        end
      end
      evest_pkg::ST_CLAMP: begin
        cmd.clamp = 1'b1;
        state_nxt = evest_pkg::ST_DIST;
      end
      evest_pkg::ST_DIST: begin
        cmd.dist_add = 1'b1;
        state_nxt = evest_pkg::ST_EMA_NEW;
      end
      evest_pkg::ST_EMA_NEW: begin
        cmd.ema_new = 1'b1;
        state_nxt = evest_pkg::ST_EMA_OLD;
      end
      evest_pkg::ST_EMA_OLD: begin
        cmd.ema_old = 1'b1;
        state_nxt = evest_pkg::ST_EMA_ROUND;
      end
      evest_pkg::ST_EMA_ROUND: begin
        cmd.ema_round = 1'b1;
        state_nxt = evest_pkg::ST_FIN;
      end
      evest_pkg::ST_FIN: begin
        if (!sts.out_busy) begin
          cmd.emit = 1'b1;
          state_nxt = evest_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = evest_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/encoder_velocity_estimator_core.sv =====
// Top level of the encoder velocity estimator
//
//   channel  direction  handshake            beat
//   in_      into core  in_valid / in_stall   action, angle, elapsed_us
//   out_     from core  out_valid / out_stall speed, distance, glitch
//   cfg_     into core  cfg_valid / cfg_ready register index, write data
//
// A plain sample passes through the 35-step radix-2 divide of the scaled delta
// by elapsed time; a glitch sample skips the divide and a clear also skips the
// delta and check steps. One sample is in flight at a time; the next is taken
// once the result sits in the output register, even while out_stall holds it.
// Reset is synchronous: estimator state is zeroed, registers take defaults.
module encoder_velocity_estimator_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_action,
  input  logic [evest_pkg::ANGLE_W-1:0]        in_angle,
  input  logic [evest_pkg::ELAPSED_W-1:0]      in_elapsed_us,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [evest_pkg::SPEED_W-1:0] out_speed,
  output logic signed [evest_pkg::DIST_W-1:0]  out_distance,
  output logic                                 out_glitch,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [evest_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [evest_pkg::CFG_DATA_W-1:0]     cfg_data
);

  evest_pkg::evest_cmd_t cmd;
  evest_pkg::evest_sts_t sts;

  evest_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  evest_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_action     (in_action),
    .in_angle      (in_angle),
    .in_elapsed_us (in_elapsed_us),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_speed     (out_speed),
    .out_distance  (out_distance),
    .out_glitch    (out_glitch)
  );

endmodule

// ===== rtl/evest_checker.sv =====
// Port-level checker for the encoder velocity estimator and its bind
`include "encoder_velocity_estimator_core_defines.svh"

module evest_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_valid,
  input logic                                 in_stall,
  input logic                                 out_valid,
  input logic                                 out_stall,
  input logic signed [evest_pkg::SPEED_W-1:0] out_speed,
  input logic signed [evest_pkg::DIST_W-1:0]  out_distance,
  input logic                                 out_glitch
);

  `EVEST_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
  `EVEST_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && out_stall,
                     $stable(out_speed) && $stable(out_distance) && $stable(out_glitch))
  `EVEST_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)
  `EVEST_ASSERT_NOW(a_result_from_work, clk, rst_n, $rose(out_valid), $past(in_stall))

endmodule

bind encoder_velocity_estimator_core evest_checker u_evest_checker (.*);

// ===== tb/tb.sv =====
// Self-checking testbench for the encoder velocity estimator core
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [evest_pkg::SPEED_W-1:0] speed;
    logic [evest_pkg::DIST_W-1:0]         distance;
    logic                                 glitch;
  } estimate_t;

  typedef struct packed {
    logic                            act;
    logic [evest_pkg::ANGLE_W-1:0]   ang;
    logic [evest_pkg::ELAPSED_W-1:0] el;
    bit                              known;
    estimate_t                       typed;
  } sample_row_t;

  typedef struct packed {
    logic [evest_pkg::MAXSPD_W-1:0] max_spd;
    logic [evest_pkg::CIRC_W-1:0]   circ;
    logic                           rev;
    logic [evest_pkg::ALPHA_W-1:0]  alpha;
  } setup_t;

  localparam logic ACT_SAMPLE = 1'b0;
  localparam logic ACT_CLEAR = 1'b1;
  localparam estimate_t NONE = '0;
  localparam int NUM_DIRECTED = 20;
  localparam int NUM_EXTREMES = 5;
  localparam int NUM_PHASES = 9;
  localparam int CALM_PHASE = 5;
  localparam int ITEMS_PER_PHASE = 48;
  localparam int STALL_LIMIT = 5000;
  localparam int HOLD_OFF = 400;
  localparam int HOLD_OFF_AFTER = 120;
  localparam int SETTLE_CYCLES = 60;

  localparam sample_row_t DIRECTED [NUM_DIRECTED] = '{
    '{ACT_CLEAR,  12'd0,    20'd0,       1'b1, '{32'sd0, 48'd0, 1'b0}},
    '{ACT_SAMPLE, 12'd0,    20'd0,       1'b1, '{32'sd0, 48'd0, 1'b1}},
    '{ACT_SAMPLE, 12'd0,    20'd1000,    1'b1, '{32'sd0, 48'd0, 1'b0}},
    '{ACT_SAMPLE, 12'd2048, 20'hFFFFF,   1'b0, NONE},
    '{ACT_SAMPLE, 12'd0,    20'hFFFFF,   1'b0, NONE},
    '{ACT_SAMPLE, 12'd4095, 20'hFFFFF,   1'b0, NONE},
    '{ACT_SAMPLE, 12'd0,    20'hFFFFF,   1'b0, NONE},
    '{ACT_SAMPLE, 12'd100,  20'd3300,    1'b0, NONE},
    '{ACT_SAMPLE, 12'd0,    20'd3300,    1'b0, NONE},
    '{ACT_SAMPLE, 12'd2048, 20'd1,       1'b0, NONE},
    '{ACT_SAMPLE, 12'd2047, 20'd1,       1'b0, NONE},
    '{ACT_SAMPLE, 12'd2047, 20'hFFFFF,   1'b0, NONE},
    '{ACT_CLEAR,  12'd4095, 20'hFFFFF,   1'b0, NONE},
    '{ACT_SAMPLE, 12'd3000, 20'd0,       1'b0, NONE},
    '{ACT_SAMPLE, 12'd4095, 20'h80000,   1'b0, NONE},
    '{ACT_SAMPLE, 12'd0,    20'd33,      1'b0, NONE},
    '{ACT_SAMPLE, 12'd1,    20'd32,      1'b0, NONE},
    '{ACT_SAMPLE, 12'hAAA,  20'h55555,   1'b0, NONE},
    '{ACT_SAMPLE, 12'h555,  20'hAAAAA,   1'b0, NONE},
    '{ACT_CLEAR,  12'd0,    20'd0,       1'b0, NONE}
  };

  localparam setup_t EXTREMES [NUM_EXTREMES] = '{
    '{16'd65535, 20'hFFFFF,  1'b1, 17'd65536},
    '{16'd0,     20'd0,      1'b0, 17'd0},
    '{16'd1280,  20'd200000, 1'b0, 17'h1FFFF},
    '{16'd1,     20'd1,      1'b1, 17'd1},
    '{16'd65535, 20'hFFFFF,  1'b0, 17'd65535}
  };

  logic                             clk = 1'b0;
  logic                             rst_n;
  logic                             in_valid;
  logic                             in_stall;
  logic                             in_action;
  logic [evest_pkg::ANGLE_W-1:0]    in_angle;
  logic [evest_pkg::ELAPSED_W-1:0]  in_elapsed_us;
  logic                             out_valid;
  logic                             out_stall;
  logic signed [evest_pkg::SPEED_W-1:0] out_speed;
  logic signed [evest_pkg::DIST_W-1:0]  out_distance;
  logic                             out_glitch;
  logic                             cfg_valid;
  logic                             cfg_ready;
  logic [evest_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [evest_pkg::CFG_DATA_W-1:0] cfg_data;

  logic [evest_pkg::MAXSPD_W-1:0]       max_spd;
  logic [evest_pkg::CIRC_W-1:0]         circ_um;
  logic                                 reverse_on;
  logic [evest_pkg::ALPHA_W-1:0]        smooth_alpha;
  logic [evest_pkg::ANGLE_W-1:0]        last_angle;
  logic signed [evest_pkg::SPEED_W-1:0] filt_speed;
  logic [evest_pkg::DIST_W-1:0]         dist_acc;

  estimate_t pending_estimates[$];
  estimate_t oldest;
  int        mismatches = 0;
  int        results_seen = 0;
  int        quiet_cycles = 0;
  bit        calm = 1'b0;

  encoder_velocity_estimator_core DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_action     (in_action),
    .in_angle      (in_angle),
    .in_elapsed_us (in_elapsed_us),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_speed     (out_speed),
    .out_distance  (out_distance),
    .out_glitch    (out_glitch),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic estimate_t track_sample(input logic act,
                                             input logic [evest_pkg::ANGLE_W-1:0] ang,
                                             input logic [evest_pkg::ELAPSED_W-1:0] el);
    estimate_t e;
    longint    d, mag, rate, lim, alpha, acc;
    e.glitch = 1'b0;
    if (act == ACT_CLEAR) begin
      dist_acc = '0;
    end else begin
      d = longint'(ang) - longint'(last_angle);
      last_angle = ang;
      if (d > 2048) d -= 4096;
      else if (d < -2048) d += 4096;
      mag = (d < 0) ? -d : d;
      if (el == '0 || mag * 125000 > 3 * longint'(max_spd) * longint'(el)) begin
        e.glitch = 1'b1;
      end else begin
        if (reverse_on) d = -d;
        rate = (d * 16000000) / longint'(el);
        lim = longint'(max_spd) * 1472 / 5;
        if (rate > lim) rate = lim;
        if (rate < -lim) rate = -lim;
        dist_acc = dist_acc + evest_pkg::DIST_W'(d * longint'(circ_um));
        alpha = (smooth_alpha > evest_pkg::ALPHA_ONE) ? 65536 : longint'(smooth_alpha);
        acc = alpha * rate + (65536 - alpha) * longint'(filt_speed);
        filt_speed = evest_pkg::SPEED_W'((acc + 32768) >>> 16);
      end
    end
    e.speed = filt_speed;
    e.distance = dist_acc;
    return e;
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [evest_pkg::ELAPSED_W-1:0] pick_elapsed();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return evest_pkg::ELAPSED_W'($urandom_range(1, 5000));
    if (r < 80) return evest_pkg::ELAPSED_W'($urandom_range(1, 50));
    if (r < 95) return evest_pkg::ELAPSED_W'($urandom_range(5000, 200000));
    return evest_pkg::ELAPSED_W'($urandom);
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    mismatches++;
  endtask

  task automatic push_sample(input logic act, input logic [evest_pkg::ANGLE_W-1:0] ang,
                             input logic [evest_pkg::ELAPSED_W-1:0] el, input bit known,
                             input estimate_t typed);
    estimate_t pred;
    int        gap;
    in_valid <= 1'b1;
    in_action <= act;
    in_angle <= ang;
    in_elapsed_us <= el;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    pred = track_sample(act, ang, el);
    pending_estimates.push_back(known ? typed : pred);
    gap = (calm || $urandom_range(0, 99) < 55) ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_estimates.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [evest_pkg::CFG_IDX_W-1:0] idx,
                           input logic [evest_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    case (idx)
      evest_pkg::CFG_MAX_SPEED: max_spd = data[evest_pkg::MAXSPD_W-1:0];
      evest_pkg::CFG_CIRC: circ_um = data[evest_pkg::CIRC_W-1:0];
      evest_pkg::CFG_REVERSE: reverse_on = data[0];
      evest_pkg::CFG_ALPHA: smooth_alpha = data[evest_pkg::ALPHA_W-1:0];
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      results_seen++;
      if (pending_estimates.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected: speed %0d distance %0d",
                                  out_speed, out_distance));
      end else begin
        oldest = pending_estimates.pop_front();
        if (out_speed !== oldest.speed)
          report_mismatch($sformatf("speed %0d, expected %0d", out_speed, oldest.speed));
        if (out_distance !== oldest.distance)
          report_mismatch($sformatf("distance %0d, expected %0d", out_distance,
                                    $signed(oldest.distance)));
        if (out_glitch !== oldest.glitch)
          report_mismatch($sformatf("glitch %0b, expected %0b", out_glitch, oldest.glitch));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin : result_sink
    int stall_left;
    bit held_off;
    stall_left = 0;
    held_off = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (!held_off && results_seen >= HOLD_OFF_AFTER) begin
        held_off = 1'b1;
        stall_left = HOLD_OFF - 1;
        out_stall <= 1'b1;
      end else if (calm || $urandom_range(0, 99) < 65) begin
        out_stall <= 1'b0;
      end else begin
        stall_left = idle_len() - 1;
        out_stall <= 1'b1;
      end
    end
  end

  initial begin : sample_source
    setup_t                          s;
    logic                            act;
    logic [evest_pkg::ANGLE_W-1:0]   ang;
    logic [evest_pkg::ELAPSED_W-1:0] el;
    longint                          bound, d;
    int                              r, pick;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_action = ACT_SAMPLE;
    in_angle = '0;
    in_elapsed_us = '0;
    cfg_valid = 1'b0;
    cfg_index = evest_pkg::CFG_MAX_SPEED;
    cfg_data = '0;
    max_spd = evest_pkg::RST_MAX_SPEED;
    circ_um = evest_pkg::RST_CIRC;
    reverse_on = 1'b0;
    smooth_alpha = evest_pkg::RST_ALPHA;
    last_angle = '0;
    filt_speed = '0;
    dist_acc = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED[i])
      push_sample(DIRECTED[i].act, DIRECTED[i].ang, DIRECTED[i].el, DIRECTED[i].known,
                  DIRECTED[i].typed);

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_results();
      if (p < NUM_EXTREMES) begin
        s = EXTREMES[p];
      end else begin
        s.max_spd = ($urandom_range(0, 3) == 0) ?
                    evest_pkg::MAXSPD_W'($urandom) :
                    evest_pkg::MAXSPD_W'($urandom_range(64, 4000));
        s.circ = evest_pkg::CIRC_W'($urandom);
        s.rev = 1'($urandom);
        s.alpha = evest_pkg::ALPHA_W'($urandom_range(0, 70000));
      end
      write_reg(evest_pkg::CFG_MAX_SPEED, {4'($urandom), s.max_spd});
      write_reg(evest_pkg::CFG_CIRC, s.circ);
      write_reg(evest_pkg::CFG_REVERSE, {19'($urandom), s.rev});
      write_reg(evest_pkg::CFG_ALPHA, {3'($urandom), s.alpha});
      cfg_valid <= 1'b0;
      calm = (p == CALM_PHASE);

      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        r = $urandom_range(0, 99);
        act = ACT_SAMPLE;
        ang = evest_pkg::ANGLE_W'($urandom);
        el = evest_pkg::ELAPSED_W'($urandom);
        if (r < 8) begin
          act = ACT_CLEAR;
        end else if (r < 13) begin
          el = '0;
        end else if (r >= 23) begin
          el = pick_elapsed();
          bound = 3 * longint'(max_spd) * longint'(el) / 125000;
          if (bound > 2048) bound = 2048;
          pick = $urandom_range(0, 9);
          if (pick == 0 && bound < 2048) d = bound + 1;
          else if (pick == 1) d = bound;
          else d = $urandom_range(0, int'(bound));
          if ($urandom_range(0, 1) == 1) d = -d;
          ang = last_angle + evest_pkg::ANGLE_W'(d);
        end
        push_sample(act, ang, el, 1'b0, NONE);
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_estimates.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_estimates.size()));
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
